[hw/rtl/flpa_pkg.sv]
// ----------------------------------------------------------------------------
// flpa_pkg
// Types and constants shared by the free-list pool allocator modules.
// ----------------------------------------------------------------------------
package flpa_pkg;

	localparam int LEN_W = 32;
	localparam int SUM_W = LEN_W + 1;

	typedef struct packed {
		logic              operation;
		logic [LEN_W-1:0]  address;
		logic [LEN_W-1:0]  length;
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_OUTSIDE = 3'd2,
		ST_NOMEM   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [LEN_W-1:0]  granted_address;
	} rsp_t;

	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic CFG_POOL_BASE = 1'b0;
	localparam logic CFG_POOL_SIZE = 1'b1;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CHECK, S_FRD, S_FEV, S_ARD, S_AEV, S_RMRD, S_RMWR,
		S_SLD, S_SCAR, S_SRD, S_SEV, S_SEND, S_MLD, S_MACC, S_MRD, S_MEV,
		S_MEND, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		C_NONE, C_INIT, C_LOAD, C_CHECK, C_FRD, C_FEV, C_ARD, C_AEV, C_RMRD,
		C_RMWR, C_SLD, C_SCAR, C_SRD, C_SEV, C_SEND, C_MLD, C_MACC, C_MRD,
		C_MEV, C_MEND
	} cmd_t;

	typedef struct packed {
		logic op;
		logic len_zero;
		logic outside;
		logic cnt_zero;
		logic cnt_small;
		logic at_end;
		logic last;
		logic overlap;
		logic adjacent;
		logic fit_gt;
		logic fit_eq;
		logic idx_zero;
		logic second;
		logic swapped;
	} dp_status_t;

endpackage

[hw/rtl/flpa_ctrl.sv]
// ----------------------------------------------------------------------------
// flpa_ctrl
// Sequencer for the allocator: steps through table scans, entry removal,
// sort passes and the merge pass, one command to the datapath per cycle.
// ----------------------------------------------------------------------------
module flpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  flpa_pkg::dp_status_t st,
	output flpa_pkg::cmd_t       cmd,
	output logic                 busy,
	output logic                 done
);
	import flpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (start) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (st.op == OP_ALLOC) begin
					state_d = (st.len_zero || st.cnt_zero) ? S_DONE : S_ARD;
				end else begin
					state_d = (st.len_zero || st.outside) ? S_DONE : S_FRD;
				end
			end
			S_FRD: state_d = st.at_end ? S_DONE : S_FEV;
			S_FEV: state_d = (st.overlap || st.adjacent) ? S_DONE : S_FRD;
			S_ARD: state_d = S_AEV;
			S_AEV: begin
				if (st.fit_gt) begin
					state_d = S_DONE;
				end else if (st.fit_eq) begin
					state_d = S_RMRD;
				end else if (!st.idx_zero) begin
					state_d = S_ARD;
				end else if (st.second) begin
					state_d = S_DONE;
				end else begin
					state_d = st.cnt_small ? S_MLD : S_SLD;
				end
			end
			S_RMRD: state_d = st.last ? S_DONE : S_RMWR;
			S_RMWR: state_d = S_RMRD;
			S_SLD:  state_d = S_SCAR;
			S_SCAR: state_d = S_SRD;
			S_SRD:  state_d = S_SEV;
			S_SEV:  state_d = st.last ? S_SEND : S_SRD;
			S_SEND: state_d = st.swapped ? S_SLD : S_MLD;
			S_MLD:  state_d = S_MACC;
			S_MACC: state_d = S_MRD;
			S_MRD:  state_d = st.at_end ? S_MEND : S_MEV;
			S_MEV:  state_d = S_MRD;
			S_MEND: state_d = S_ARD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd  = C_NONE;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			S_INIT: cmd = C_INIT;
			S_IDLE: begin
				busy = 1'b0;
				cmd  = start ? C_LOAD : C_NONE;
			end
			S_CHECK: cmd = C_CHECK;
			S_FRD:   cmd = C_FRD;
			S_FEV:   cmd = C_FEV;
			S_ARD:   cmd = C_ARD;
			S_AEV:   cmd = C_AEV;
			S_RMRD:  cmd = C_RMRD;
			S_RMWR:  cmd = C_RMWR;
			S_SLD:   cmd = C_SLD;
			S_SCAR:  cmd = C_SCAR;
			S_SRD:   cmd = C_SRD;
			S_SEV:   cmd = C_SEV;
			S_SEND:  cmd = C_SEND;
			S_MLD:   cmd = C_MLD;
			S_MACC:  cmd = C_MACC;
			S_MRD:   cmd = C_MRD;
			S_MEV:   cmd = C_MEV;
			S_MEND:  cmd = C_MEND;
			S_DONE:  done = 1'b1;
			default: cmd = C_NONE;
		endcase
	end

endmodule

[hw/rtl/flpa_dp.sv]
// ----------------------------------------------------------------------------
// flpa_dp
// Datapath: extent table memory, region registers, scan cursor, carry
// entry for sort and merge, and the result registers.
// ----------------------------------------------------------------------------
module flpa_dp #(
	parameter int MAX_EXTENTS = 64,
	parameter int ADDR_BITS   = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  flpa_pkg::cmd_t                  cmd,
	input  flpa_pkg::req_t                  req,
	input  logic                            cfg_we,
	input  logic                            cfg_idx,
	input  logic [flpa_pkg::LEN_W-1:0]      cfg_data,
	output flpa_pkg::dp_status_t            st,
	output flpa_pkg::rsp_t                  rsp
);
	import flpa_pkg::*;

	localparam int IW  = $clog2(MAX_EXTENTS);
	localparam int CW  = $clog2(MAX_EXTENTS + 1);
	localparam int EAW = (ADDR_BITS < LEN_W) ? ADDR_BITS : LEN_W;

	logic [EAW-1:0]   mem_b [MAX_EXTENTS];
	logic [LEN_W-1:0] mem_l [MAX_EXTENTS];

	logic [EAW-1:0]   pool_base_q;
	logic [LEN_W-1:0] pool_size_q;
	logic [CW-1:0]    cnt_q, idx_q, wp_q;
	logic             op_q, second_q, swapped_q;
	logic [EAW-1:0]   addr_q, rb_q, cb_q;
	logic [LEN_W-1:0] len_q, rl_q, cl_q;
	logic [2:0]       status_q;
	logic [LEN_W-1:0] grant_q;

	logic [CW-1:0]    idx_p1, idx_m1, cnt_m1, cnt_p1, wp_p1;
	logic [SUM_W-1:0] a_s, l_s, rb_s, rl_s, cb_s, cl_s;
	logic [SUM_W-1:0] req_end, pool_end, rend, cend, split;
	logic             outside, overlap, adjacent, fit_gt, fit_eq, carry_gt, abut;
	logic             full, at_end;

	logic             we;
	logic [IW-1:0]    waddr, raddr;
	logic [EAW-1:0]   wb;
	logic [LEN_W-1:0] wl;

	assign idx_p1 = idx_q + 1'b1;
	assign idx_m1 = idx_q - 1'b1;
	assign cnt_m1 = cnt_q - 1'b1;
	assign cnt_p1 = cnt_q + 1'b1;
	assign wp_p1  = wp_q + 1'b1;

	assign a_s  = SUM_W'(addr_q);
	assign l_s  = SUM_W'(len_q);
	assign rb_s = SUM_W'(rb_q);
	assign rl_s = SUM_W'(rl_q);
	assign cb_s = SUM_W'(cb_q);
	assign cl_s = SUM_W'(cl_q);

	assign req_end  = a_s + l_s;
	assign pool_end = SUM_W'(pool_base_q) + SUM_W'(pool_size_q);
	assign rend     = rb_s + rl_s;
	assign cend     = cb_s + cl_s;
	assign split    = rend - l_s;

	assign outside  = (addr_q < pool_base_q) || (req_end > pool_end);
	assign overlap  = ((rb_s <= a_s) && ((a_s - rb_s) < rl_s))
			|| ((a_s <= rb_s) && ((rb_s - a_s) < l_s));
	assign adjacent = (rend == a_s) || (req_end == rb_s);
	assign fit_gt   = rl_q > len_q;
	assign fit_eq   = rl_q == len_q;
	assign carry_gt = cb_q > rb_q;
	assign abut     = cend == rb_s;
	assign full     = cnt_q == CW'(MAX_EXTENTS);
	assign at_end   = idx_q == cnt_q;

	assign st.op        = op_q;
	assign st.len_zero  = len_q == '0;
	assign st.outside   = outside;
	assign st.cnt_zero  = cnt_q == '0;
	assign st.cnt_small = cnt_q < CW'(2);
	assign st.at_end    = at_end;
	assign st.last      = idx_p1 == cnt_q;
	assign st.overlap   = overlap;
	assign st.adjacent  = adjacent;
	assign st.fit_gt    = fit_gt;
	assign st.fit_eq    = fit_eq;
	assign st.idx_zero  = idx_q == '0;
	assign st.second    = second_q;
	assign st.swapped   = swapped_q;

	assign rsp.status          = status_q;
	assign rsp.granted_address = grant_q;

	assign raddr = (cmd == C_RMRD) ? idx_p1[IW-1:0] : idx_q[IW-1:0];

	// table write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wb    = cb_q;
		wl    = cl_q;
		if (cfg_we) begin
			we    = 1'b1;
			waddr = '0;
			wb    = (cfg_idx == CFG_POOL_BASE) ? cfg_data[EAW-1:0] : pool_base_q;
			wl    = (cfg_idx == CFG_POOL_SIZE) ? cfg_data : pool_size_q;
		end else begin
			case (cmd)
				C_INIT: begin
					we    = 1'b1;
					waddr = '0;
					wb    = pool_base_q;
					wl    = pool_size_q;
				end
				C_FRD: begin
					we    = at_end && !full;
					waddr = cnt_q[IW-1:0];
					wb    = addr_q;
					wl    = len_q;
				end
				C_FEV: begin
					we = !overlap && adjacent;
					wb = (addr_q < rb_q) ? addr_q : rb_q;
					wl = rl_q + len_q;
				end
				C_AEV: begin
					we = fit_gt;
					wb = rb_q;
					wl = rl_q - len_q;
				end
				C_RMWR: begin
					we = 1'b1;
					wb = rb_q;
					wl = rl_q;
				end
				C_SEV: begin
					we    = 1'b1;
					waddr = idx_m1[IW-1:0];
					wb    = carry_gt ? rb_q : cb_q;
					wl    = carry_gt ? rl_q : cl_q;
				end
				C_SEND: begin
					we    = 1'b1;
					waddr = idx_m1[IW-1:0];
				end
				C_MEV: begin
					we    = !abut;
					waddr = wp_q[IW-1:0];
				end
				C_MEND: begin
					we    = 1'b1;
					waddr = wp_q[IW-1:0];
				end
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_b[waddr] <= wb;
			mem_l[waddr] <= wl;
		end
		rb_q <= mem_b[raddr];
		rl_q <= mem_l[raddr];
	end

	// region registers and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			pool_size_q <= LEN_W'(1);
			cnt_q       <= CW'(1);
		end else if (cfg_we) begin
			if (cfg_idx == CFG_POOL_BASE) begin
				pool_base_q <= cfg_data[EAW-1:0];
				cnt_q       <= CW'(pool_size_q != '0);
			end else begin
				pool_size_q <= cfg_data;
				cnt_q       <= CW'(cfg_data != '0);
			end
		end else begin
			case (cmd)
				C_INIT: cnt_q <= CW'(pool_size_q != '0);
				C_FRD:  if (at_end && !full) cnt_q <= cnt_p1;
				C_RMRD: if (idx_p1 == cnt_q) cnt_q <= cnt_m1;
				C_MEND: cnt_q <= wp_p1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// cursor, carry entry and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			wp_q      <= '0;
			op_q      <= OP_FREE;
			second_q  <= 1'b0;
			swapped_q <= 1'b0;
			status_q  <= ST_OK;
			grant_q   <= '0;
		end else begin
			case (cmd)
				C_LOAD: begin
					op_q     <= req.operation;
					second_q <= 1'b0;
					status_q <= ST_OK;
					grant_q  <= '0;
				end
				C_CHECK: begin
					idx_q <= (op_q == OP_ALLOC) ? cnt_m1 : '0;
					if (len_q == '0) begin
						status_q <= ST_INVALID;
					end else if (op_q == OP_ALLOC && cnt_q == '0) begin
						status_q <= ST_NOMEM;
					end else if (op_q == OP_FREE && outside) begin
						status_q <= ST_OUTSIDE;
					end
				end
				C_FRD: begin
					if (at_end && full) status_q <= ST_FULL;
				end
				C_FEV: begin
					if (overlap) begin
						status_q <= ST_INVALID;
					end
					idx_q <= idx_p1;
				end
				C_AEV: begin
					if (fit_gt) begin
						grant_q <= split[LEN_W-1:0];
					end else if (fit_eq) begin
						grant_q <= LEN_W'(rb_q);
					end else if (idx_q != '0) begin
						idx_q <= idx_m1;
					end else if (second_q) begin
						status_q <= ST_NOMEM;
					end
				end
				C_RMWR: idx_q <= idx_p1;
				C_SLD:  swapped_q <= 1'b0;
				C_SCAR: idx_q <= CW'(1);
				C_SEV: begin
					if (carry_gt) swapped_q <= 1'b1;
					idx_q <= idx_p1;
				end
				C_SEND: idx_q <= '0;
				C_MACC: begin
					idx_q <= CW'(1);
					wp_q  <= '0;
				end
				C_MEV: begin
					if (!abut) wp_q <= wp_p1;
					idx_q <= idx_p1;
				end
				C_MEND: begin
					idx_q    <= wp_q;
					second_q <= 1'b1;
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			C_LOAD: begin
				addr_q <= req.address[EAW-1:0];
				len_q  <= req.length;
			end
			C_SCAR, C_MACC: begin
				cb_q <= rb_q;
				cl_q <= rl_q;
			end
			C_SEV: begin
				if (!carry_gt) begin
					cb_q <= rb_q;
					cl_q <= rl_q;
				end
			end
			C_MEV: begin
				if (abut) begin
					cl_q <= cl_q + rl_q;
				end else begin
					cb_q <= rb_q;
					cl_q <= rl_q;
				end
			end
			default: cb_q <= cb_q;
		endcase
	end

endmodule

[hw/rtl/free_list_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// free_list_pool_allocator_core
// Free-extent allocator over one configured region with merge on free and
// sort-and-merge retry on allocate failure.
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  request   start, busy, req                in (accepted when start & !busy)
//  result    done, rsp                       out (one-cycle strobe)
//  config    cfg_we, cfg_idx, cfg_data       in (write when cfg_we)
//
//  A request scans the table with a read and an evaluate step per entry,
//  and removing an exact fit moves each later entry down with a read and
//  a write step; the table memory has registered reads.
//  A failed allocate adds bubble-sort passes (up to count passes) and a
//  merge pass before the second scan.
//  After reset the block loads the table in its init state before it
//  accepts a request. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module free_list_pool_allocator_core #(
	parameter int MAX_EXTENTS = 64,
	parameter int ADDR_BITS   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  flpa_pkg::req_t              req,
	output logic                        done,
	output flpa_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [flpa_pkg::LEN_W-1:0]  cfg_data
);
	import flpa_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	flpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	flpa_dp #(
		.MAX_EXTENTS (MAX_EXTENTS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.st       (st),
		.rsp      (rsp)
	);

endmodule
